@@ rtl/crfs_pkg.sv @@
package crfs_pkg;

  // Coordinate width of the clip and height registers
  localparam int COORD_BITS    = 12;
  localparam int STRIDE_BITS   = 13;
  localparam int LW_BITS       = 8;
  localparam int IN_BITS       = 16;
  // Internal signed coordinate: holds a 16-bit input plus a line width without wrap
  localparam int CW            = IN_BITS + 2;
  localparam int OFF_BITS      = 24;
  localparam int LEN_BITS      = 17;
  localparam int IDX_BITS      = 3;
  localparam int CFG_DATA_BITS = (COORD_BITS > STRIDE_BITS) ? COORD_BITS : STRIDE_BITS;
  localparam int NBANDS        = 4;
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = $clog2(QDEPTH);

  // Command kinds
  localparam logic [1:0] KIND_RAW     = 2'd0;
  localparam logic [1:0] KIND_CLIP    = 2'd1;
  localparam logic [1:0] KIND_OUTLINE = 2'd2;

  // Register indexes
  localparam logic [IDX_BITS-1:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_CLIP_RIGHT  = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_CLIP_TOP    = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_HEIGHT_M1   = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_ROW_STRIDE  = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_LINE_W_H    = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_LINE_W_V    = 3'd7;

  // Reset values
  localparam logic [COORD_BITS-1:0]  RST_CLIP_LEFT   = COORD_BITS'(0);
  localparam logic [COORD_BITS-1:0]  RST_CLIP_RIGHT  = COORD_BITS'(639);
  localparam logic [COORD_BITS-1:0]  RST_CLIP_TOP    = COORD_BITS'(0);
  localparam logic [COORD_BITS-1:0]  RST_CLIP_BOTTOM = COORD_BITS'(479);
  localparam logic [COORD_BITS-1:0]  RST_HEIGHT_M1   = COORD_BITS'(479);
  localparam logic [STRIDE_BITS-1:0] RST_ROW_STRIDE  = STRIDE_BITS'(640);
  localparam logic [LW_BITS-1:0]     RST_LINE_W      = LW_BITS'(1);

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  clip_left;
    logic [COORD_BITS-1:0]  clip_right;
    logic [COORD_BITS-1:0]  clip_top;
    logic [COORD_BITS-1:0]  clip_bottom;
    logic [COORD_BITS-1:0]  height_m1;
    logic [STRIDE_BITS-1:0] row_stride;
    logic [LW_BITS-1:0]     line_w_h;
    logic [LW_BITS-1:0]     line_w_v;
  } cfg_t;

  typedef struct packed {
    coord_t xl;
    coord_t xr;
    coord_t yt;
    coord_t yb;
  } rect_t;

  // One band handed from the front to the back
  typedef struct packed {
    rect_t      r;
    logic [1:0] edge_id;
    logic       last;
  } band_t;

  function automatic coord_t smin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t smax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ rtl/crfs_cfg.sv @@
module crfs_cfg import crfs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [IDX_BITS-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Decode the register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLIP_LEFT:   cfg_d.clip_left   = cfg_wdata_i[COORD_BITS-1:0];
        REG_CLIP_RIGHT:  cfg_d.clip_right  = cfg_wdata_i[COORD_BITS-1:0];
        REG_CLIP_TOP:    cfg_d.clip_top    = cfg_wdata_i[COORD_BITS-1:0];
        REG_CLIP_BOTTOM: cfg_d.clip_bottom = cfg_wdata_i[COORD_BITS-1:0];
        REG_HEIGHT_M1:   cfg_d.height_m1   = cfg_wdata_i[COORD_BITS-1:0];
        REG_ROW_STRIDE:  cfg_d.row_stride  = cfg_wdata_i[STRIDE_BITS-1:0];
        REG_LINE_W_H:    cfg_d.line_w_h    = cfg_wdata_i[LW_BITS-1:0];
        REG_LINE_W_V:    cfg_d.line_w_v    = cfg_wdata_i[LW_BITS-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_left   <= RST_CLIP_LEFT;
      cfg_q.clip_right  <= RST_CLIP_RIGHT;
      cfg_q.clip_top    <= RST_CLIP_TOP;
      cfg_q.clip_bottom <= RST_CLIP_BOTTOM;
      cfg_q.height_m1   <= RST_HEIGHT_M1;
      cfg_q.row_stride  <= RST_ROW_STRIDE;
      cfg_q.line_w_h    <= RST_LINE_W;
      cfg_q.line_w_v    <= RST_LINE_W;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/crfs_front.sv @@
module crfs_front import crfs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                kind_i,
  input  logic signed [IN_BITS-1:0] x_left_i,
  input  logic signed [IN_BITS-1:0] x_right_i,
  input  logic signed [IN_BITS-1:0] y_top_i,
  input  logic signed [IN_BITS-1:0] y_bottom_i,
  output logic                      band_push_o,
  output band_t                     band_o,
  input  logic                      band_full_i
);

  coord_t xl, xr, yt, yb, lv, lh;
  rect_t  raw_d [NBANDS];
  rect_t  rect_q [NBANDS];
  logic [NBANDS-1:0] mask_d, mask_q, new_mask;
  logic              clip_q;
  rect_t  clipped [NBANDS];
  logic [NBANDS-1:0] band_ok, pending, sel_oh, rest;
  logic              finish, accept;
  rect_t             sel_rect;
  logic [1:0]        sel_id;
  coord_t            cl, cr, ct, cb;

  // Derive the raw bands of the incoming command
  always_comb begin
    xl = coord_t'(x_left_i);
    xr = coord_t'(x_right_i);
    yt = coord_t'(y_top_i);
    yb = coord_t'(y_bottom_i);
    lv = coord_t'(cfg_i.line_w_v);
    lh = coord_t'(cfg_i.line_w_h);
    for (int i = 0; i < NBANDS; i++) begin
      raw_d[i] = '{xl: xl, xr: xr, yt: yt, yb: yb};
    end
    if (kind_i == KIND_OUTLINE) begin
      raw_d[0].yb = smin(coord_t'(yt + lv - 1), yb);
    end
    raw_d[1].yt = smax(coord_t'(yb - lv + 1), yt);
    raw_d[2].xr = smin(coord_t'(xl + lh - 1), xr);
    raw_d[3].xl = smax(coord_t'(xr - lh + 1), xl);
    case (kind_i)
      KIND_RAW, KIND_CLIP: new_mask = 4'b0001;
      KIND_OUTLINE:        new_mask = 4'b1111;
      default:             new_mask = 4'b0000;
    endcase
  end

  // Clip the held bands of a clipped command and pick the lowest pending non-empty one
  always_comb begin
    cl = coord_t'(cfg_i.clip_left);
    cr = coord_t'(cfg_i.clip_right);
    ct = coord_t'(cfg_i.clip_top);
    cb = coord_t'(cfg_i.clip_bottom);
    sel_rect = rect_q[0];
    sel_id   = 2'd0;
    for (int i = 0; i < NBANDS; i++) begin
      clipped[i] = rect_q[i];
      if (clip_q) begin
        clipped[i].xl = smax(rect_q[i].xl, cl);
        clipped[i].xr = smin(rect_q[i].xr, cr);
        clipped[i].yt = smax(rect_q[i].yt, ct);
        clipped[i].yb = smin(rect_q[i].yb, cb);
      end
      band_ok[i] = (clipped[i].xr >= clipped[i].xl) && (clipped[i].yb >= clipped[i].yt);
    end
    pending = mask_q & band_ok;
    sel_oh  = pending & (~pending + NBANDS'(1));
    rest    = pending & ~sel_oh;
    for (int i = 0; i < NBANDS; i++) begin
      if (sel_oh[i]) begin
        sel_rect = clipped[i];
        sel_id   = 2'(i);
      end
    end
  end

  assign band_push_o = (pending != '0) && !band_full_i;
  assign band_o      = '{r: sel_rect, edge_id: sel_id, last: (rest == '0)};

  // Slot frees once no band is left to hand on
  assign finish = (pending == '0) || (band_push_o && (rest == '0));
  assign full   = (mask_q != '0) && !finish;
  assign accept = push && !full;

  // Advance the band mask
  always_comb begin
    if (accept) begin
      mask_d = new_mask;
    end else if (finish) begin
      mask_d = '0;
    end else if (band_push_o) begin
      mask_d = mask_q & ~sel_oh;
    end else begin
      mask_d = mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Hold the command's bands
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rect_q <= raw_d;
      clip_q <= (kind_i != KIND_RAW);
    end
  end

  // A band handed on is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_push_o |-> (band_o.r.xr >= band_o.r.xl) && (band_o.r.yb >= band_o.r.yt))
    else $error("empty band handed on");

  // The last band of a command leaves the slot free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_push_o && band_o.last && !push |=> mask_q == '0)
    else $error("slot still busy after last band");

endmodule

@@ rtl/crfs_queue.sv @@
module crfs_queue import crfs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  band_t wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output band_t rdata_o,
  output logic  empty_o
);

  band_t                mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [QPTR_BITS:0]   count_d, count_q;
  logic                 do_wr, do_rd;

  assign full_o  = (count_q == (QPTR_BITS+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + QPTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + QPTR_BITS'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + (QPTR_BITS+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - (QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming band
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_BITS+1)'(QDEPTH))
    else $error("band queue overflow");

endmodule

@@ rtl/crfs_back.sv @@
module crfs_back import crfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  band_t               band_i,
  input  logic                band_empty_i,
  output logic                band_rd_o,
  output logic                empty,
  input  logic                pop,
  output logic [OFF_BITS-1:0] start_offset_o,
  output logic [LEN_BITS-1:0] span_width_o,
  output logic [LEN_BITS-1:0] row_count_o,
  output logic [1:0]          edge_res_o,
  output logic                last_o
);

  logic                s1_v_q, s2_v_q, s1_rdy, s2_rdy;
  coord_t              diff;
  logic [OFF_BITS-1:0] diff_w;
  logic [OFF_BITS-1:0] xl_q, prod_q, off_q;
  logic [LEN_BITS-1:0] w1_q, r1_q, w2_q, r2_q;
  logic [1:0]          e1_q, e2_q;
  logic                l1_q, l2_q;

  assign s2_rdy    = !s2_v_q || pop;
  assign s1_rdy    = !s1_v_q || s2_rdy;
  assign band_rd_o = !band_empty_i && s1_rdy;

  // Row distance from the bottom of stored memory, wrapped to the offset width
  assign diff   = coord_t'(coord_t'(cfg_i.height_m1) - band_i.r.yb);
  assign diff_w = OFF_BITS'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= !band_empty_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // Multiply stage: row product and lengths
  always_ff @(posedge clk_i) begin
    if (band_rd_o) begin
      xl_q   <= OFF_BITS'(band_i.r.xl);
      prod_q <= OFF_BITS'(diff_w * OFF_BITS'(cfg_i.row_stride));
      w1_q   <= LEN_BITS'(band_i.r.xr - band_i.r.xl + 1);
      r1_q   <= LEN_BITS'(band_i.r.yb - band_i.r.yt + 1);
      e1_q   <= band_i.edge_id;
      l1_q   <= band_i.last;
    end
  end

  // Output stage: add the column and hold until popped
  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      off_q <= xl_q + prod_q;
      w2_q  <= w1_q;
      r2_q  <= r1_q;
      e2_q  <= e1_q;
      l2_q  <= l1_q;
    end
  end

  assign empty          = !s2_v_q;
  assign start_offset_o = off_q;
  assign span_width_o   = w2_q;
  assign row_count_o    = r2_q;
  assign edge_res_o     = e2_q;
  assign last_o         = l2_q;

  // A span on offer always covers at least one byte and one row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (w2_q != '0) && (r2_q != '0))
    else $error("zero-sized span on output");

endmodule

@@ rtl/clipped_rect_fill_spans.sv @@
// Clipped rectangle fill span generator. Each command (raw fill, clipped fill
// or clipped outline) is turned into up to four fill spans, each carrying the
// byte offset of its lowest stored row in a bottom-up 8-bit frame buffer, its
// width, its row count, which edge band it is and a mark on the last span of
// the command. Commands that clip away completely, and kind 3, yield no span.
// A command is taken at the same edge at which the previous one hands on its
// last band. The band sequencer emits one band per cycle into the four-entry
// band queue while it is not full. The first span of a command passes the
// command register, the band queue, the multiply stage and the output register
// on its way to the result side; after that results may be popped one per
// cycle while spans keep coming. Registers are written through the plain write
// port and should only be changed while the block holds no work.
module clipped_rect_fill_spans import crfs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [IDX_BITS-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                kind_i,
  input  logic signed [IN_BITS-1:0] x_left_i,
  input  logic signed [IN_BITS-1:0] x_right_i,
  input  logic signed [IN_BITS-1:0] y_top_i,
  input  logic signed [IN_BITS-1:0] y_bottom_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [OFF_BITS-1:0]       start_offset_o,
  output logic [LEN_BITS-1:0]       span_width_o,
  output logic [LEN_BITS-1:0]       row_count_o,
  output logic [1:0]                edge_res_o,
  output logic                      last_o
);

  cfg_t  cfg;
  band_t band_in, band_out;
  logic  band_wr, band_full, band_rd, band_empty;

  // Configuration registers
  crfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Accept commands and split them into bands
  crfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .x_left_i    (x_left_i),
    .x_right_i   (x_right_i),
    .y_top_i     (y_top_i),
    .y_bottom_i  (y_bottom_i),
    .band_push_o (band_wr),
    .band_o      (band_in),
    .band_full_i (band_full)
  );

  // Decouple the band sequencer from the span arithmetic
  crfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (band_wr),
    .wdata_i (band_in),
    .full_o  (band_full),
    .rd_i    (band_rd),
    .rdata_o (band_out),
    .empty_o (band_empty)
  );

  // Compute offsets and lengths
  crfs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .band_i         (band_out),
    .band_empty_i   (band_empty),
    .band_rd_o      (band_rd),
    .empty          (empty),
    .pop            (pop),
    .start_offset_o (start_offset_o),
    .span_width_o   (span_width_o),
    .row_count_o    (row_count_o),
    .edge_res_o     (edge_res_o),
    .last_o         (last_o)
  );

endmodule

@@ tb/clipped_rect_fill_spans_tb.sv @@
`timescale 1ns / 1ps

module clipped_rect_fill_spans_tb;
  import crfs_pkg::*;

  // Kind with no meaning to the block, and the edge tags of a span
  localparam logic [1:0] KIND_NONE   = 2'd3;
  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_BOTTOM = 2'd1;
  localparam logic [1:0] EDGE_LEFT   = 2'd2;
  localparam logic [1:0] EDGE_RIGHT  = 2'd3;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 80;

  typedef struct {
    logic [1:0]                kind;
    logic signed [IN_BITS-1:0] xl;
    logic signed [IN_BITS-1:0] xr;
    logic signed [IN_BITS-1:0] yt;
    logic signed [IN_BITS-1:0] yb;
  } fill_cmd_t;

  typedef struct {
    logic [OFF_BITS-1:0] offset;
    logic [LEN_BITS-1:0] width;
    logic [LEN_BITS-1:0] rows;
    logic [1:0]          edge_id;
    logic                last;
  } span_t;

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      cfg_we     = 1'b0;
  logic [IDX_BITS-1:0]       cfg_idx    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata  = '0;
  logic                      push       = 1'b0;
  logic                      full;
  logic [1:0]                kind_i     = KIND_RAW;
  logic signed [IN_BITS-1:0] x_left_i   = '0;
  logic signed [IN_BITS-1:0] x_right_i  = '0;
  logic signed [IN_BITS-1:0] y_top_i    = '0;
  logic signed [IN_BITS-1:0] y_bottom_i = '0;
  logic                      empty;
  logic                      pop        = 1'b0;
  logic [OFF_BITS-1:0]       start_offset_o;
  logic [LEN_BITS-1:0]       span_width_o;
  logic [LEN_BITS-1:0]       row_count_o;
  logic [1:0]                edge_res_o;
  logic                      last_o;

  // Shadow copy of the register file
  logic [COORD_BITS-1:0]  clip_l  = RST_CLIP_LEFT;
  logic [COORD_BITS-1:0]  clip_r  = RST_CLIP_RIGHT;
  logic [COORD_BITS-1:0]  clip_t  = RST_CLIP_TOP;
  logic [COORD_BITS-1:0]  clip_b  = RST_CLIP_BOTTOM;
  logic [COORD_BITS-1:0]  hm1     = RST_HEIGHT_M1;
  logic [STRIDE_BITS-1:0] stride  = RST_ROW_STRIDE;
  logic [LW_BITS-1:0]     lw_h    = RST_LINE_W;
  logic [LW_BITS-1:0]     lw_v    = RST_LINE_W;

  fill_cmd_t cmd_q[$];
  span_t     spans_due[$];
  span_t     cmd_spans[$];

  int cmds_sent  = 0;
  int cmds_taken = 0;
  int res_seen   = 0;
  int mismatches = 0;
  int n_setups   = 0;
  int n_holds    = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  bit took_cmd   = 1'b0;
  bit took_res   = 1'b0;
  bit calm       = 1'b0;
  int tx_gap     = 0;
  int rx_gap     = 0;
  int hold_left  = 0;
  int quiet      = 0;

  clipped_rect_fill_spans uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .x_left_i       (x_left_i),
    .x_right_i      (x_right_i),
    .y_top_i        (y_top_i),
    .y_bottom_i     (y_bottom_i),
    .empty          (empty),
    .pop            (pop),
    .start_offset_o (start_offset_o),
    .span_width_o   (span_width_o),
    .row_count_o    (row_count_o),
    .edge_res_o     (edge_res_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Clip one band if asked and append it to the command's spans unless empty
  function automatic void add_span(bit clip, longint xl, longint xr, longint yt, longint yb,
                                   logic [1:0] eid);
    longint off;
    span_t  s;
    if (clip) begin
      if (xl < longint'(clip_l)) xl = longint'(clip_l);
      if (xr > longint'(clip_r)) xr = longint'(clip_r);
      if (yt < longint'(clip_t)) yt = longint'(clip_t);
      if (yb > longint'(clip_b)) yb = longint'(clip_b);
    end
    if (xr < xl || yb < yt) return;
    off       = xl + (longint'(hm1) - yb) * longint'(stride);
    s.offset  = off[OFF_BITS-1:0];
    s.width   = LEN_BITS'(xr - xl + 1);
    s.rows    = LEN_BITS'(yb - yt + 1);
    s.edge_id = eid;
    s.last    = 1'b0;
    cmd_spans.push_back(s);
  endfunction

  // Work out the spans one command yields and queue them for checking
  function automatic void queue_spans(fill_cmd_t c);
    longint xl, xr, yt, yb, lv, lh, a;
    xl = c.xl;
    xr = c.xr;
    yt = c.yt;
    yb = c.yb;
    lv = longint'(lw_v);
    lh = longint'(lw_h);
    cmd_spans.delete();
    case (c.kind)
      KIND_RAW: add_span(1'b0, xl, xr, yt, yb, EDGE_TOP);
      KIND_CLIP: add_span(1'b1, xl, xr, yt, yb, EDGE_TOP);
      KIND_OUTLINE: begin
        a = yt + lv - 1;
        if (a > yb) a = yb;
        add_span(1'b1, xl, xr, yt, a, EDGE_TOP);
        a = yb - lv + 1;
        if (a < yt) a = yt;
        add_span(1'b1, xl, xr, a, yb, EDGE_BOTTOM);
        a = xl + lh - 1;
        if (a > xr) a = xr;
        add_span(1'b1, xl, a, yt, yb, EDGE_LEFT);
        a = xr - lh + 1;
        if (a < xl) a = xl;
        add_span(1'b1, a, xr, yt, yb, EDGE_RIGHT);
      end
      default: ;
    endcase
    foreach (cmd_spans[i]) begin
      cmd_spans[i].last = (i == cmd_spans.size() - 1);
      spans_due.push_back(cmd_spans[i]);
    end
  endfunction

  function automatic string span_str(span_t s);
    return $sformatf("off=%06h width=%0d rows=%0d edge=%0d last=%0b",
                     s.offset, s.width, s.rows, s.edge_id, s.last);
  endfunction

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  // Coordinate mostly near the window, sometimes anywhere or at the limits
  function automatic int rand_coord(int lo, int hi);
    int reach;
    reach = (hi > lo) ? hi - lo : 0;
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return lo - 64 + int'($urandom_range(0, reach + 128));
    endcase
  endfunction

  // Far side of a rectangle: mostly a small extent, sometimes inverted or random
  function automatic int other_side(int near, int lo, int hi);
    case ($urandom_range(0, 9))
      0: return rand_coord(lo, hi);
      1: return near - int'($urandom_range(1, 4));
      default: return near + int'($urandom_range(0, 48));
    endcase
  endfunction

  task automatic send(logic [1:0] k, int xl, int xr, int yt, int yb);
    fill_cmd_t c;
    c.kind = k;
    c.xl   = IN_BITS'(xl);
    c.xr   = IN_BITS'(xr);
    c.yt   = IN_BITS'(yt);
    c.yb   = IN_BITS'(yb);
    cmd_q.push_back(c);
    cmds_sent++;
  endtask

  task automatic send_random();
    int         xl, yt, pick;
    logic [1:0] k;
    pick = $urandom_range(0, 19);
    k = (pick < 5) ? KIND_RAW : (pick < 11) ? KIND_CLIP :
        (pick < 19) ? KIND_OUTLINE : KIND_NONE;
    xl = rand_coord(clip_l, clip_r);
    yt = rand_coord(clip_t, clip_b);
    send(k, xl, other_side(xl, clip_l, clip_r), yt, other_side(yt, clip_t, clip_b));
  endtask

  // One register write transaction; keep the shadow copy in step
  task automatic write_reg(logic [IDX_BITS-1:0] idx, int val);
    logic [CFG_DATA_BITS-1:0] d;
    d = CFG_DATA_BITS'(val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    case (idx)
      REG_CLIP_LEFT:   clip_l = d[COORD_BITS-1:0];
      REG_CLIP_RIGHT:  clip_r = d[COORD_BITS-1:0];
      REG_CLIP_TOP:    clip_t = d[COORD_BITS-1:0];
      REG_CLIP_BOTTOM: clip_b = d[COORD_BITS-1:0];
      REG_HEIGHT_M1:   hm1    = d[COORD_BITS-1:0];
      REG_ROW_STRIDE:  stride = d[STRIDE_BITS-1:0];
      REG_LINE_W_H:    lw_h   = d[LW_BITS-1:0];
      REG_LINE_W_V:    lw_v   = d[LW_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(int cl, int cr, int ct, int cb, int hm, int st, int lh, int lv);
    write_reg(REG_CLIP_LEFT, cl);
    write_reg(REG_CLIP_RIGHT, cr);
    write_reg(REG_CLIP_TOP, ct);
    write_reg(REG_CLIP_BOTTOM, cb);
    write_reg(REG_HEIGHT_M1, hm);
    write_reg(REG_ROW_STRIDE, st);
    write_reg(REG_LINE_W_H, lh);
    write_reg(REG_LINE_W_V, lv);
    n_setups++;
  endtask

  // Wait for every command to be taken and every span to drain, then let the pipe empty
  task automatic settle();
    while (cmds_taken != cmds_sent || spans_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Command driver: hold the current transaction until taken, with random gaps
  always @(negedge clk_i) begin : cmd_driver
    fill_cmd_t c;
    if (rst_ni && (!push || took_cmd)) begin
      if (push && !calm && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 8);
      if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        kind_i     <= c.kind;
        x_left_i   <= c.xl;
        x_right_i  <= c.xr;
        y_top_i    <= c.yt;
        y_bottom_i <= c.yb;
        push       <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Span receiver: random stall bursts plus an occasional long hold-off
  always @(negedge clk_i) begin : span_receiver
    if (rst_ni) begin
      if (took_res && !calm && res_seen % 150 == 40) begin
        hold_left = HOLD_CYCLES;
        n_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor: predict on each command transaction, check each span transaction
  always @(posedge clk_i) begin : span_monitor
    fill_cmd_t c;
    span_t     got, want;
    if (!rst_ni) begin
      took_cmd <= 1'b0;
      took_res <= 1'b0;
    end else begin
      took_cmd <= push && !full;
      took_res <= pop && !empty;
      if (push && !full) begin
        c.kind = kind_i;
        c.xl   = x_left_i;
        c.xr   = x_right_i;
        c.yt   = y_top_i;
        c.yb   = y_bottom_i;
        queue_spans(c);
        kind_count[kind_i]++;
        cmds_taken <= cmds_taken + 1;
      end
      if (pop && !empty) begin
        got.offset  = start_offset_o;
        got.width   = span_width_o;
        got.rows    = row_count_o;
        got.edge_id = edge_res_o;
        got.last    = last_o;
        if (spans_due.size() == 0) begin
          log_mismatch({"span with none expected: ", span_str(got)});
        end else begin
          want = spans_due.pop_front();
          if (got.offset !== want.offset || got.width !== want.width ||
              got.rows !== want.rows || got.edge_id !== want.edge_id ||
              got.last !== want.last)
            log_mismatch({"span expected ", span_str(want), " got ", span_str(got)});
        end
        res_seen <= res_seen + 1;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if ((push && !full) || (pop && !empty)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int cl, ct;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed commands on the reset window: extremes, empties, clip-outs, overlaps
    send(KIND_RAW, 10, 20, 5, 8);
    send(KIND_RAW, -32768, 32767, -32768, 32767);
    send(KIND_RAW, 32767, 32767, 32767, 32767);
    send(KIND_RAW, -32768, -32768, -32768, -32768);
    send(KIND_RAW, 20, 10, 0, 0);
    send(KIND_RAW, 0, 0, 9, 3);
    send(KIND_CLIP, 100, 200, 50, 60);
    send(KIND_CLIP, -50, 700, -10, 500);
    send(KIND_CLIP, 700, 800, 10, 20);
    send(KIND_CLIP, 10, 20, -30, -1);
    send(KIND_CLIP, 50, 40, 10, 20);
    send(KIND_CLIP, 0, 639, 0, 479);
    send(KIND_OUTLINE, 100, 110, 200, 210);
    send(KIND_OUTLINE, 5, 5, 5, 5);
    send(KIND_OUTLINE, 5, 6, 7, 7);
    send(KIND_OUTLINE, -5, 5, 470, 490);
    send(KIND_OUTLINE, 1000, 1010, 0, 5);
    send(KIND_OUTLINE, 30, 20, 0, 5);
    send(KIND_OUTLINE, -32768, 32767, -32768, 32767);
    send(KIND_NONE, 0, 10, 0, 10);
    settle();

    // Narrow window, a stride of 4, thicker lines
    load_setup(100, 500, 50, 300, 479, 4, 3, 2);
    repeat (60) send_random();
    settle();

    // Zero line widths: outlines produce nothing
    load_setup(0, 639, 0, 479, 479, 640, 0, 0);
    send(KIND_OUTLINE, 10, 20, 10, 20);
    send(KIND_OUTLINE, -5, 3, 0, 0);
    repeat (20) send_random();
    settle();

    // Inverted window: only raw fills get through
    load_setup(600, 100, 400, 10, 479, 640, 2, 2);
    send(KIND_RAW, 1, 2, 3, 4);
    send(KIND_CLIP, 0, 639, 0, 479);
    repeat (20) send_random();
    settle();

    // Upper extremes of every register but the left and top clip edges, which are zero
    load_setup(0, 4095, 0, 4095, 4095, 8191, 255, 255);
    send(KIND_OUTLINE, -32768, 32767, -32768, 32767);
    send(KIND_CLIP, -32768, 32767, -32768, 32767);
    repeat (40) send_random();
    settle();

    // Single-pixel window at the far corner, zero stride and zero height-minus-one
    load_setup(4095, 8191, 4095, 4095, 0, 0, 1, 255);
    send(KIND_CLIP, 4095, 4095, 4095, 4095);
    send(KIND_OUTLINE, 4000, 5000, 4000, 5000);
    repeat (20) send_random();
    settle();

    // Random settings; the last phase runs without idling
    for (int p = 0; p < 4; p++) begin
      cl = $urandom_range(0, 600);
      ct = $urandom_range(0, 400);
      load_setup(cl, cl + int'($urandom_range(0, 700)), ct, ct + int'($urandom_range(0, 500)),
                 $urandom_range(0, 4095), $urandom_range(4, 4096),
                 ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 12),
                 ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 12));
      if (p == 3) calm = 1'b1;
      repeat (40) send_random();
      settle();
    end

    $display("Ran %0d commands (%0d raw, %0d clipped, %0d outline, %0d unused kind) under %0d",
             cmds_taken, kind_count[KIND_RAW], kind_count[KIND_CLIP],
             kind_count[KIND_OUTLINE], kind_count[KIND_NONE], n_setups + 1);
    $display("register settings, checking %0d spans with %0d long output stalls",
             res_seen, n_holds);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
